// ----- sv/pdtk_pkg.sv -----
// ----------------------------------------------------------------------------
// pdtk_pkg
// shared constants, types and helpers for the prefix dictionary lookup
// ----------------------------------------------------------------------------
package pdtk_pkg;

    localparam int DICT_ENTRIES   = 16384;
    localparam int KEY_CHARS      = 12;
    localparam int MAX_CANDIDATES = 8;
    localparam int GATHER_LIMIT   = 8192;
    localparam int CODE_SLOTS     = 12;
    localparam int KEY_W          = 60;
    localparam int WORD_W         = 24;
    localparam int FREQ_W         = 32;
    localparam int IDX_W          = 14;
    localparam int CNT_W          = 15;
    localparam int LEN_W          = 4;
    localparam int RANK_W         = 3;
    localparam int GCNT_W         = 14;
    localparam logic [4:0] LETTER_MAX = 5'd25;

    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_LETTER = 3'd1,
        ACT_BACK   = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_COMMIT = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        KIND_CAND   = 2'd0,
        KIND_NONE   = 2'd1,
        KIND_COMMIT = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_BS_RD,
        ST_BS_CMP,
        ST_HIT_RD,
        ST_HIT_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_INS,
        ST_MERGE,
        ST_EMIT,
        ST_COMMIT_OUT
    } state_t;

    // keep codes up to the first zero code
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] kept;
        logic             live;
        kept = '0;
        live = 1'b1;
        for (int i = 0; i < CODE_SLOTS; i++) begin
            if (key[5*(CODE_SLOTS-1-i) +: 5] == 5'd0)
                live = 1'b0;
            if (live)
                kept[5*(CODE_SLOTS-1-i) +: 5] = key[5*(CODE_SLOTS-1-i) +: 5];
        end
        return kept;
    endfunction

    // mask covering the first len codes
    function automatic logic [KEY_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int i = 0; i < CODE_SLOTS; i++)
            if (LEN_W'(i) < len)
                m[5*(CODE_SLOTS-1-i) +: 5] = 5'h1f;
        return m;
    endfunction

endpackage

// ----- sv/pdtk_dict_mem.sv -----
// ----------------------------------------------------------------------------
// pdtk_dict_mem
// dictionary storage: key, word and frequency, one port, registered read
// ----------------------------------------------------------------------------
module pdtk_dict_mem (
    input  logic                        clk,
    input  logic                        we,
    input  logic [pdtk_pkg::IDX_W-1:0]  addr,
    input  logic [pdtk_pkg::KEY_W-1:0]  wr_key,
    input  logic [pdtk_pkg::WORD_W-1:0] wr_word,
    input  logic [pdtk_pkg::FREQ_W-1:0] wr_freq,
    output logic [pdtk_pkg::KEY_W-1:0]  rd_key,
    output logic [pdtk_pkg::WORD_W-1:0] rd_word,
    output logic [pdtk_pkg::FREQ_W-1:0] rd_freq
);
    import pdtk_pkg::*;

    logic [KEY_W-1:0]  key_mem  [DICT_ENTRIES];
    logic [WORD_W-1:0] word_mem [DICT_ENTRIES];
    logic [FREQ_W-1:0] freq_mem [DICT_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[addr]  <= wr_key;
            word_mem[addr] <= wr_word;
            freq_mem[addr] <= wr_freq;
        end
        rd_key  <= key_mem[addr];
        rd_word <= word_mem[addr];
        rd_freq <= freq_mem[addr];
    end

endmodule

// ----- sv/prefix_dictionary_top_k_lookup_unit.sv -----
// ----------------------------------------------------------------------------
// prefix_dictionary_top_k_lookup_unit
// typed-prefix lookup with ranked completion candidates
// ----------------------------------------------------------------------------
// usage: an input item (valid/ready) loads a dictionary slot, edits the typed
// buffer (letter, backspace, clear) or commits a ranked candidate. entries
// must be loaded sorted by key, then the dictionary size written through cfg_we.
// a load gives no result. an edit runs, for each buffer length from longest
// down until a length finds a match, a binary search over the dictionary and
// then scans the matching run (at most 8192 entries), inserting each entry
// into a ranked list; all steps go through one memory port.
// results leave through an output register: one item per candidate (kind 0)
// or one kind 1 item, last marking the final one; a commit gives one item.
// while out_valid waits for out_ready the sequencer holds, and in_ready is
// low from acceptance until the last result is taken.
// reset clears the buffer and the ranked list; the dictionary memory is not
// cleared and must be loaded before it is searched.
// ----------------------------------------------------------------------------
module prefix_dictionary_top_k_lookup_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pdtk_pkg::CNT_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  action,
    input  logic [pdtk_pkg::IDX_W-1:0]  entry_index,
    input  logic [pdtk_pkg::KEY_W-1:0]  entry_key,
    input  logic [pdtk_pkg::WORD_W-1:0] entry_word,
    input  logic [pdtk_pkg::FREQ_W-1:0] entry_frequency,
    input  logic [4:0]                  letter,
    input  logic [2:0]                  pick,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [pdtk_pkg::WORD_W-1:0] word,
    output logic [2:0]                  rank,
    output logic [3:0]                  hit_len,
    output logic [3:0]                  buf_len,
    output logic                        last
);
    import pdtk_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  dict_size_reg;
    logic [4:0]        typed_reg [CODE_SLOTS];
    logic [4:0]        typed_next [CODE_SLOTS];
    logic [LEN_W-1:0]  typed_count_reg, typed_count_next;
    logic [LEN_W-1:0]  match_len_reg, match_len_next;
    logic [WORD_W-1:0] rw_reg [MAX_CANDIDATES];
    logic [WORD_W-1:0] rw_next [MAX_CANDIDATES];
    logic [LEN_W-1:0]  rcount_reg, rcount_next;

    // exact and completion lists during a scan
    logic [WORD_W-1:0] ew_reg [MAX_CANDIDATES];
    logic [WORD_W-1:0] ew_next [MAX_CANDIDATES];
    logic [FREQ_W-1:0] ef_reg [MAX_CANDIDATES];
    logic [FREQ_W-1:0] ef_next [MAX_CANDIDATES];
    logic [WORD_W-1:0] cw_reg [MAX_CANDIDATES];
    logic [WORD_W-1:0] cw_next [MAX_CANDIDATES];
    logic [FREQ_W-1:0] cf_reg [MAX_CANDIDATES];
    logic [FREQ_W-1:0] cf_next [MAX_CANDIDATES];
    logic [LEN_W-1:0]  ec_reg, ec_next, cc_reg, cc_next;
    logic              exact_reg, exact_next;

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [KEY_W-1:0]  pfx_reg, pfx_next;
    logic [CNT_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [GCNT_W-1:0] gn_reg, gn_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic              ins_c_reg, ins_c_next;
    logic [WORD_W-1:0] iw_reg, iw_next;
    logic [FREQ_W-1:0] if_reg, if_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [2:0]        pick_reg, pick_next;

    logic              ov_reg, ov_next;
    logic [1:0]        kind_reg, kind_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [2:0]        rank_reg, rank_next;
    logic [3:0]        ml_reg, ml_next, bl_reg, bl_next;
    logic              last_reg, last_next;

    // remembers that the running refresh belongs to a commit
    logic              commit_run_reg;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    logic [KEY_W-1:0]  rd_key;
    logic [WORD_W-1:0] rd_word;
    logic [FREQ_W-1:0] rd_freq;

    pdtk_dict_mem u_mem (
        .clk     (clk),
        .we      (mem_we),
        .addr    (mem_addr),
        .wr_key  (normalize_key(entry_key)),
        .wr_word (entry_word),
        .wr_freq (entry_frequency),
        .rd_key  (rd_key),
        .rd_word (rd_word),
        .rd_freq (rd_freq)
    );

    logic [KEY_W-1:0] pmask;
    logic [KEY_W-1:0] typed_value;
    logic             hit;
    logic [CNT_W-1:0] mid;
    logic             accept;
    logic [FREQ_W-1:0] lf_sel;
    logic [LEN_W-1:0]  lc_sel;
    logic [LEN_W:0]    merge_sum;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE) && !ov_reg;
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign pmask     = prefix_mask(len_reg);
    assign hit       = ((rd_key ^ pfx_reg) & pmask) == '0;
    assign merge_sum = {1'b0, ec_reg} + {1'b0, cc_reg};

    always_comb
    begin
        typed_value = '0;
        for (int i = 0; i < CODE_SLOTS; i++)
            typed_value[5*(CODE_SLOTS-1-i) +: 5] = typed_reg[i] + 5'd1;
    end

    always_comb
    begin
        lf_sel = ins_c_reg ? cf_reg[pos_reg[RANK_W-1:0]] : ef_reg[pos_reg[RANK_W-1:0]];
        lc_sel = ins_c_reg ? cc_reg : ec_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            dict_size_reg   <= '0;
            typed_count_reg <= '0;
            match_len_reg   <= '0;
            rcount_reg      <= '0;
            ov_reg          <= 1'b0;
            for (int i = 0; i < CODE_SLOTS; i++)
                typed_reg[i] <= '0;
            for (int i = 0; i < MAX_CANDIDATES; i++)
                rw_reg[i] <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
                dict_size_reg <= cfg_data;
            typed_count_reg <= typed_count_next;
            match_len_reg   <= match_len_next;
            rcount_reg      <= rcount_next;
            ov_reg          <= ov_next;
            typed_reg       <= typed_next;
            rw_reg          <= rw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ew_reg <= ew_next;  ef_reg <= ef_next;
        cw_reg <= cw_next;  cf_reg <= cf_next;
        ec_reg <= ec_next;  cc_reg <= cc_next;
        exact_reg <= exact_next;
        len_reg <= len_next;  pfx_reg <= pfx_next;
        lo_reg <= lo_next;  hi_reg <= hi_next;  total_reg <= total_next;
        gn_reg <= gn_next;  pos_reg <= pos_next;  ins_c_reg <= ins_c_next;
        iw_reg <= iw_next;  if_reg <= if_next;  k_reg <= k_next;
        pick_reg <= pick_next;
        kind_reg <= kind_next;  word_reg <= word_next;  rank_reg <= rank_next;
        ml_reg <= ml_next;  bl_reg <= bl_next;  last_reg <= last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        typed_next       = typed_reg;
        typed_count_next = typed_count_reg;
        match_len_next   = match_len_reg;
        rw_next          = rw_reg;
        rcount_next      = rcount_reg;
        ew_next = ew_reg;  ef_next = ef_reg;  cw_next = cw_reg;  cf_next = cf_reg;
        ec_next = ec_reg;  cc_next = cc_reg;  exact_next = exact_reg;
        len_next = len_reg;  pfx_next = pfx_reg;
        lo_next = lo_reg;  hi_next = hi_reg;  total_next = total_reg;
        gn_next = gn_reg;  pos_next = pos_reg;  ins_c_next = ins_c_reg;
        iw_next = iw_reg;  if_next = if_reg;  k_next = k_reg;
        pick_next = pick_reg;
        ov_next = ov_reg;  kind_next = kind_reg;  word_next = word_reg;
        rank_next = rank_reg;  ml_next = ml_reg;  bl_next = bl_reg;
        last_next = last_reg;
        mem_we   = 1'b0;
        mem_addr = entry_index;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pick_next = pick;
                    total_next = (dict_size_reg > CNT_W'(DICT_ENTRIES))
                                 ? CNT_W'(DICT_ENTRIES) : dict_size_reg;
                    case (action)
                        ACT_LOAD:
                            mem_we = 1'b1;
                        ACT_LETTER:
                        begin
                            if (letter <= LETTER_MAX &&
                                typed_count_reg < LEN_W'(KEY_CHARS))
                            begin
                                typed_next[typed_count_reg] = letter;
                                typed_count_next = typed_count_reg + 1'b1;
                                state_next = ST_LEN;
                            end
                            else
                                state_next = ST_MERGE;
                        end
                        ACT_BACK:
                        begin
                            if (typed_count_reg != '0)
                            begin
                                typed_next[typed_count_reg - 1'b1] = '0;
                                typed_count_next = typed_count_reg - 1'b1;
                                state_next = ST_LEN;
                            end
                            else
                                state_next = ST_MERGE;
                        end
                        ACT_CLEAR:
                        begin
                            for (int i = 0; i < CODE_SLOTS; i++)
                                typed_next[i] = '0;
                            typed_count_next = '0;
                            state_next = ST_LEN;
                        end
                        ACT_COMMIT:
                        begin
                            if (LEN_W'(pick) < rcount_reg)
                            begin
                                iw_next = rw_reg[pick];
                                for (int i = 0; i < CODE_SLOTS; i++)
                                    typed_next[i] = '0;
                                typed_count_next = '0;
                                state_next = ST_LEN;
                            end
                            else
                            begin
                                ov_next = 1'b1;
                                kind_next = KIND_REJECT;
                                word_next = '0;
                                rank_next = pick;
                                ml_next = match_len_reg;
                                bl_next = typed_count_reg;
                                last_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    // a fresh refresh starts from the full buffer length
                    len_next = typed_count_next;
                    rcount_next = (state_next == ST_LEN) ? '0 : rcount_reg;
                    match_len_next = (state_next == ST_LEN) ? '0 : match_len_reg;
                end
            end
            ST_LEN:
            begin
                if (len_reg == '0)
                begin
                    ec_next = '0;  cc_next = '0;
                    state_next = ST_MERGE;
                end
                else
                begin
                    pfx_next = typed_value & prefix_mask(len_reg);
                    lo_next = '0;
                    hi_next = total_reg;
                    state_next = ST_BS_RD;
                end
            end
            ST_BS_RD:
            begin
                mem_addr = mid[IDX_W-1:0];
                if (lo_reg < hi_reg)
                    state_next = ST_BS_CMP;
                else
                begin
                    mem_addr = lo_reg[IDX_W-1:0];
                    state_next = (lo_reg < total_reg) ? ST_HIT_RD : ST_HIT_CMP;
                end
            end
            ST_BS_CMP:
            begin
                if (rd_key < pfx_reg)
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
                state_next = ST_BS_RD;
            end
            ST_HIT_RD:
            begin
                mem_addr = lo_reg[IDX_W-1:0];
                state_next = ST_HIT_CMP;
            end
            ST_HIT_CMP:
            begin
                if (lo_reg < total_reg && hit)
                begin
                    match_len_next = len_reg;
                    ec_next = '0;  cc_next = '0;  exact_next = 1'b1;
                    gn_next = '0;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    len_next = len_reg - 1'b1;
                    state_next = ST_LEN;
                end
            end
            ST_SCAN_RD:
            begin
                mem_addr = lo_reg[IDX_W-1:0];
                if (lo_reg < total_reg && {1'b0, gn_reg} < (GCNT_W+1)'(GATHER_LIMIT))
                    state_next = ST_SCAN_CMP;
                else
                    state_next = ST_MERGE;
            end
            ST_SCAN_CMP:
            begin
                if (!hit)
                    state_next = ST_MERGE;
                else
                begin
                    ins_c_next = !(exact_reg && rd_key == pfx_reg);
                    if (ins_c_next)
                        exact_next = 1'b0;
                    iw_next = rd_word;
                    if_next = rd_freq;
                    pos_next = '0;
                    lo_next = lo_reg + 1'b1;
                    gn_next = gn_reg + 1'b1;
                    state_next = ST_INS;
                end
            end
            ST_INS:
            begin
                // one list position is checked per cycle
                if (pos_reg < lc_sel && lf_sel >= if_reg)
                    pos_next = pos_reg + 1'b1;
                else
                begin
                    if (pos_reg < LEN_W'(MAX_CANDIDATES))
                    begin
                        for (int j = MAX_CANDIDATES - 1; j > 0; j--)
                        begin
                            if (LEN_W'(j) > pos_reg)
                            begin
                                if (ins_c_reg)
                                begin
                                    cw_next[j] = cw_reg[j-1];
                                    cf_next[j] = cf_reg[j-1];
                                end
                                else
                                begin
                                    ew_next[j] = ew_reg[j-1];
                                    ef_next[j] = ef_reg[j-1];
                                end
                            end
                        end
                        if (ins_c_reg)
                        begin
                            cw_next[pos_reg[RANK_W-1:0]] = iw_reg;
                            cf_next[pos_reg[RANK_W-1:0]] = if_reg;
                            if (cc_reg < LEN_W'(MAX_CANDIDATES))
                                cc_next = cc_reg + 1'b1;
                        end
                        else
                        begin
                            ew_next[pos_reg[RANK_W-1:0]] = iw_reg;
                            ef_next[pos_reg[RANK_W-1:0]] = if_reg;
                            if (ec_reg < LEN_W'(MAX_CANDIDATES))
                                ec_next = ec_reg + 1'b1;
                        end
                    end
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MERGE:
            begin
                // fresh refresh: build the ranked list from both groups
                if (rcount_reg == '0 && match_len_reg != '0)
                begin
                    for (int i = 0; i < MAX_CANDIDATES; i++)
                    begin
                        if (LEN_W'(i) < ec_reg)
                            rw_next[i] = ew_reg[i];
                        else
                            rw_next[i] = cw_reg[(i - int'(ec_reg)) & (MAX_CANDIDATES-1)];
                    end
                    rcount_next = (merge_sum > (LEN_W+1)'(MAX_CANDIDATES))
                                  ? LEN_W'(MAX_CANDIDATES) : merge_sum[LEN_W-1:0];
                end
                k_next = '0;
                // a commit refresh ends in the commit result instead of the list
                state_next = commit_run_reg ? ST_COMMIT_OUT : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    ml_next = match_len_reg;
                    bl_next = typed_count_reg;
                    if (rcount_reg == '0)
                    begin
                        kind_next = KIND_NONE;
                        word_next = '0;
                        rank_next = '0;
                        last_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        kind_next = KIND_CAND;
                        word_next = rw_reg[k_reg[RANK_W-1:0]];
                        rank_next = k_reg[RANK_W-1:0];
                        last_next = (k_reg + 1'b1 == rcount_reg);
                        k_next = k_reg + 1'b1;
                        if (k_reg + 1'b1 == rcount_reg)
                            state_next = ST_IDLE;
                    end
                end
            end
            ST_COMMIT_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    kind_next = KIND_COMMIT;
                    word_next = iw_reg;
                    rank_next = pick_reg;
                    ml_next = '0;
                    bl_next = '0;
                    last_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            commit_run_reg <= 1'b0;
        else if (accept)
            commit_run_reg <= (action == ACT_COMMIT);
    end

    assign out_valid = ov_reg;
    assign kind      = kind_reg;
    assign word      = word_reg;
    assign rank      = rank_reg;
    assign hit_len   = ml_reg;
    assign buf_len   = bl_reg;
    assign last      = last_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        typed_count_reg <= LEN_W'(KEY_CHARS))
        else $error("buffer overflow");
    a_match_le_buf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (match_len_reg <= typed_count_reg))
        else $error("match longer than buffer");
    a_rank_max: assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg <= LEN_W'(MAX_CANDIDATES))
        else $error("ranked list overflow");

endmodule
